/* src/pqft_pkg.sv */
// Shared types and codes for the sorted priority queue.
// Used by the queue cell, the top level and the port checker.
package pqft_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic signed [DataW-1:0] prio;
    logic [DataW-1:0]        payload;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

/* src/pqft_cell.sv */
// One slot of the sorted register chain: holds an entry, shifts with its neighbors.
// Depends on pqft_pkg.
module pqft_cell
  import pqft_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  entry_t     new_entry_i,
  input  entry_t     prev_entry_i,
  input  logic       prev_keep_i,
  input  entry_t     next_entry_i,
  output entry_t     entry_o,
  output logic       keep_o
);

  entry_t entry_q, entry_d;

  assign keep_o = occupied_i && (entry_q.prio >= new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (prev_keep_i) begin
        entry_d = new_entry_i;
      end else begin
        entry_d = prev_entry_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* src/priority_queue_fifo_ties.sv */
// Top level of the sorted priority queue: a chain of cells plus count and result beat.
// Depends on pqft_pkg and pqft_cell.
//
// Usage:
//   Input channel s_axis: one beat per operation. tuser carries the opcode
//   (insert, remove highest, peek highest); tdata carries payload and signed
//   priority for an insert. Output channel m_axis: one beat per operation with
//   the removed or peeked payload, the entry count after the operation, and
//   the status (ok, full, empty) in tuser.
//   Entries are kept sorted, highest priority in cell zero, equal priorities
//   in arrival order. Every cell compares against the new priority at once,
//   so an operation completes in the cycle it is accepted.
//   The result beat is registered and appears in the cycle after the input beat.
//   Throughput: one operation per cycle while the receiver takes results.
//   When the receiver stalls, the result beat holds in the output register and
//   s_axis_tready drops until that beat is taken.
//   Reset empties the queue and clears the output valid flag; no clearing pass.
module priority_queue_fifo_ties
  import pqft_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] payload_in, [63:32] priority_in
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] payload_out, [36:32] count, [39:37] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [DataW-1:0]  out_payload_q, out_payload_d;
  logic [CountW-1:0] out_count_q;
  logic [1:0]        out_status_q, out_status_d;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_entry [CAPACITY];
  logic       cell_keep  [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = (count_q == '0);

  assign new_entry.payload = s_axis_tdata[31:0];
  assign new_entry.prio    = $signed(s_axis_tdata[63:32]);

  assign ctrl.ins = accept && (s_axis_tuser == OP_INSERT) && !full;
  assign ctrl.rem = accept && (s_axis_tuser == OP_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_entry, next_entry;
    logic   prev_keep;
    if (i == 0) begin : g_first
      assign prev_entry = new_entry;
      assign prev_keep  = 1'b1;
    end else begin : g_mid
      assign prev_entry = cell_entry[i-1];
      assign prev_keep  = cell_keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end
    pqft_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (count_q > CntW'(i)),
      .new_entry_i  (new_entry),
      .prev_entry_i (prev_entry),
      .prev_keep_i  (prev_keep),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[i]),
      .keep_o       (cell_keep[i])
    );
  end

  always_comb begin
    count_d       = count_q;
    out_payload_d = '0;
    out_status_d  = ST_OK;
    case (s_axis_tuser)
      OP_INSERT: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_payload_d = cell_entry[0].payload;
          count_d       = count_q - CntW'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_payload_d = cell_entry[0].payload;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_payload_q <= out_payload_d;
      out_status_q  <= out_status_d;
      out_count_q   <= CountW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_payload_q};
  assign m_axis_tuser  = out_status_q;

endmodule

/* src/pqft_checker.sv */
// Port checker for the sorted priority queue, bound to the top level.
// Depends on pqft_pkg and priority_queue_fifo_ties.
module pqft_checker
  import pqft_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input beat taken while result beat stalled");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[36:32] == '0))
    else $error("empty status with nonzero payload or count");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[36:32] == CountW'(CAPACITY)))
    else $error("full status with wrong payload or count");

endmodule

bind priority_queue_fifo_ties pqft_checker #(.CAPACITY(CAPACITY)) u_pqft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
